// ----- design/ffpa_pkg.sv -----
// Package: shared types and codes for the first-fit partition allocator.
`timescale 1ns / 1ps
package ffpa_pkg;
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_NO_JOB  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Operation broadcast to every cell for one cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET_USED,
        OP_SPLIT,
        OP_FREE,
        OP_MERGE_NEXT,
        OP_MERGE_PREV
    } t_op;
endpackage

// ----- design/ffpa_cell.sv -----
// One table entry; shifts with its neighbors on insert and remove.
`timescale 1ns / 1ps
module ffpa_cell #(
    parameter int ADDRESS_BITS = 16,
    parameter int JOB_ID_BITS  = 8,
    parameter int IDX_BITS     = 4,
    parameter logic [ADDRESS_BITS-1:0] RST_START = '0,
    parameter logic [ADDRESS_BITS-1:0] RST_LEN   = '0,
    parameter logic RST_VALID = 1'b0,
    parameter logic [IDX_BITS-1:0] MY_IDX = '0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ffpa_pkg::t_op           i_op,
    input  logic [IDX_BITS-1:0]     i_idx,
    input  logic [ADDRESS_BITS-1:0] i_size,
    input  logic [JOB_ID_BITS-1:0]  i_job,
    // lower neighbor (index-1) and upper neighbor (index+1)
    input  logic [ADDRESS_BITS-1:0] i_lo_start,
    input  logic [ADDRESS_BITS-1:0] i_lo_len,
    input  logic [JOB_ID_BITS-1:0]  i_lo_owner,
    input  logic                    i_lo_used,
    input  logic                    i_lo_valid,
    input  logic [ADDRESS_BITS-1:0] i_hi_start,
    input  logic [ADDRESS_BITS-1:0] i_hi_len,
    input  logic [JOB_ID_BITS-1:0]  i_hi_owner,
    input  logic                    i_hi_used,
    input  logic                    i_hi_valid,
    output logic [ADDRESS_BITS-1:0] o_start,
    output logic [ADDRESS_BITS-1:0] o_len,
    output logic [JOB_ID_BITS-1:0]  o_owner,
    output logic                    o_used,
    output logic                    o_valid
);
    logic [ADDRESS_BITS-1:0] r_start, n_start, r_len, n_len;
    logic [JOB_ID_BITS-1:0]  r_owner, n_owner;
    logic                    r_used, n_used, r_valid, n_valid;

    always_comb begin
        n_start = r_start; n_len = r_len; n_owner = r_owner;
        n_used = r_used; n_valid = r_valid;
        case (i_op)
            ffpa_pkg::OP_SET_USED: begin
                if (MY_IDX == i_idx) begin
                    n_used = 1'b1; n_owner = i_job;
                end
            end
            ffpa_pkg::OP_SPLIT: begin
                // entry at idx keeps low part, leftover goes to idx+1, rest shift up
                if (MY_IDX == i_idx) begin
                    n_len = i_size; n_used = 1'b1; n_owner = i_job;
                end else if (MY_IDX == i_idx + 1'b1) begin
                    n_start = i_lo_start + i_size; n_len = i_lo_len - i_size;
                    n_owner = '0; n_used = 1'b0; n_valid = 1'b1;
                end else if (MY_IDX > i_idx) begin
                    n_start = i_lo_start; n_len = i_lo_len; n_owner = i_lo_owner;
                    n_used = i_lo_used; n_valid = i_lo_valid;
                end
            end
            ffpa_pkg::OP_FREE: begin
                if (MY_IDX == i_idx) begin
                    n_used = 1'b0; n_owner = '0;
                end
            end
            ffpa_pkg::OP_MERGE_NEXT, ffpa_pkg::OP_MERGE_PREV: begin
                // idx absorbs idx+1, entries above shift down
                if (MY_IDX == i_idx) begin
                    n_len = r_len + i_hi_len;
                end else if (MY_IDX > i_idx) begin
                    n_start = i_hi_start; n_len = i_hi_len; n_owner = i_hi_owner;
                    n_used = i_hi_used; n_valid = i_hi_valid;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= RST_START; r_len <= RST_LEN; r_owner <= '0;
            r_used <= 1'b0; r_valid <= RST_VALID;
        end else begin
            r_start <= n_start; r_len <= n_len; r_owner <= n_owner;
            r_used <= n_used; r_valid <= n_valid;
        end
    end

    assign o_start = r_start;
    assign o_len   = r_len;
    assign o_owner = r_owner;
    assign o_used  = r_used;
    assign o_valid = r_valid;
endmodule

// ----- design/first_fit_partition_allocator.sv -----
// Top level: request sequencer over a chain of partition cells.
`timescale 1ns / 1ps
// First-fit partition allocator. Each transaction is an allocate or a free
// and yields one result. The sequencer scans the cell chain one entry per
// cycle, then applies up to three table updates in which every cell moves in
// parallel with its neighbor. The scan is followed by the decision; a free
// then applies the release and up to two merges. The result is loaded into
// the output register, and the next request is taken once the sequencer is
// back in idle. One request is handled at a time. The result sits in an
// output register while the next request is taken. A stalled result holds
// only the final output step.
module first_fit_partition_allocator #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDRESS_BITS  = 16,
    parameter int JOB_ID_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_job_id,
    input  logic [15:0] i_request_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_block_start,
    output logic [15:0] o_block_length
);
    localparam int IB = $clog2(TABLE_ENTRIES);
    localparam int N  = TABLE_ENTRIES;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_MERGE_N, S_MERGE_P, S_OUT
    } t_state;

    logic [ADDRESS_BITS-1:0] c_start [N];
    logic [ADDRESS_BITS-1:0] c_len   [N];
    logic [JOB_ID_BITS-1:0]  c_owner [N];
    logic                    c_used  [N];
    logic                    c_valid [N];

    t_state                  r_state;
    logic                    r_cmd;
    logic [JOB_ID_BITS-1:0]  r_job;
    logic [ADDRESS_BITS-1:0] r_size;
    logic [IB-1:0]           r_idx;
    logic                    r_found;
    ffpa_pkg::t_op           r_op;
    logic [IB-1:0]           r_opidx;
    logic                    r_oval;
    logic [1:0]              r_status;
    logic [15:0]             r_rs, r_rl;
    // result being built while the previous one may still be held
    logic [1:0]              r_res_status;
    logic [15:0]             r_res_start, r_res_len;

    // request width adapters
    logic [ADDRESS_BITS-1:0] w_size_in;
    logic [JOB_ID_BITS-1:0]  w_job_in;
    assign w_size_in = ADDRESS_BITS'({16'd0, i_request_size});
    assign w_job_in  = JOB_ID_BITS'({16'd0, i_job_id});

    // cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        localparam logic [ADDRESS_BITS-1:0] RS =
            ADDRESS_BITS'(g == 1 ? 300 : g == 2 ? 1000 : 0);
        localparam logic [ADDRESS_BITS-1:0] RL =
            ADDRESS_BITS'(g == 0 ? 200 : g == 1 ? 500 : g == 2 ? 1000 : 0);
        localparam int LO = (g == 0) ? 0 : g - 1;
        localparam int HI = (g == N - 1) ? N - 1 : g + 1;
        logic hv;
        assign hv = (g == N - 1) ? 1'b0 : c_valid[HI];
        ffpa_cell #(
            .ADDRESS_BITS(ADDRESS_BITS), .JOB_ID_BITS(JOB_ID_BITS), .IDX_BITS(IB),
            .RST_START(RS), .RST_LEN(RL), .RST_VALID(g < 3), .MY_IDX(IB'(g))
        ) u_cell (
            .i_clk, .i_rst_n,
            .i_op(r_op), .i_idx(r_opidx), .i_size(r_size), .i_job(r_job),
            .i_lo_start(c_start[LO]), .i_lo_len(c_len[LO]), .i_lo_owner(c_owner[LO]),
            .i_lo_used(c_used[LO]), .i_lo_valid(c_valid[LO]),
            .i_hi_start(g == N - 1 ? '0 : c_start[HI]),
            .i_hi_len(g == N - 1 ? '0 : c_len[HI]),
            .i_hi_owner(g == N - 1 ? '0 : c_owner[HI]),
            .i_hi_used(g == N - 1 ? 1'b0 : c_used[HI]),
            .i_hi_valid(hv),
            .o_start(c_start[g]), .o_len(c_len[g]), .o_owner(c_owner[g]),
            .o_used(c_used[g]), .o_valid(c_valid[g])
        );
    end

    // scan match on the current entry
    logic w_hit;
    always_comb begin
        if (r_cmd == ffpa_pkg::CMD_ALLOC)
            w_hit = c_valid[r_idx] && !c_used[r_idx] && c_len[r_idx] >= r_size;
        else
            w_hit = c_valid[r_idx] && c_used[r_idx] && c_owner[r_idx] == r_job;
    end

    logic [IB-1:0] w_nx, w_pv;
    assign w_nx = r_idx + 1'b1;
    assign w_pv = r_idx - 1'b1;
    logic w_last;
    assign w_last = (r_idx == IB'(N - 1));

    // next-entry merge check does not read the freed entry's used bit, so it holds while the free is applied
    logic w_mn, w_mp;
    assign w_mn = !w_last && c_valid[w_nx] && !c_used[w_nx]
                  && (c_start[r_idx] + c_len[r_idx]) == c_start[w_nx];
    assign w_mp = (r_idx != '0) && !c_used[w_pv]
                  && (c_start[w_pv] + c_len[w_pv]) == c_start[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= ffpa_pkg::OP_NONE;
            r_oval  <= 1'b0;
        end else begin
            // held result leaves when taken, unless a new one replaces it
            if (r_state != S_OUT && r_oval && !i_stall) r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_op <= ffpa_pkg::OP_NONE;
                    if (i_valid) begin
                        r_cmd <= i_command; r_job <= w_job_in; r_size <= w_size_in;
                        r_idx <= '0; r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_op <= ffpa_pkg::OP_NONE;
                    if (w_hit) begin
                        r_found <= 1'b1; r_state <= S_DECIDE;
                    end else if (w_last || !c_valid[w_nx]) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= w_nx;
                    end
                end
                S_DECIDE: begin
                    r_res_start <= 16'(c_start[r_idx]);
                    r_opidx <= r_idx;
                    r_state <= S_OUT;
                    if (r_cmd == ffpa_pkg::CMD_ALLOC) begin
                        r_res_len <= 16'(r_size);
                        if (!r_found || r_size == '0) begin
                            r_res_status <= ffpa_pkg::ST_NO_FIT;
                            r_op <= ffpa_pkg::OP_NONE;
                        end else if (c_len[r_idx] == r_size) begin
                            r_res_status <= ffpa_pkg::ST_DONE;
                            r_op <= ffpa_pkg::OP_SET_USED;
                        end else if (c_valid[IB'(N - 1)]) begin
                            r_res_status <= ffpa_pkg::ST_FULL;
                            r_op <= ffpa_pkg::OP_NONE;
                        end else begin
                            r_res_status <= ffpa_pkg::ST_DONE;
                            r_op <= ffpa_pkg::OP_SPLIT;
                        end
                    end else begin
                        r_res_len <= 16'(c_len[r_idx]);
                        if (!r_found) begin
                            r_res_status <= ffpa_pkg::ST_NO_JOB;
                            r_op <= ffpa_pkg::OP_NONE;
                        end else begin
                            r_res_status <= ffpa_pkg::ST_DONE;
                            r_op <= ffpa_pkg::OP_FREE;
                            r_state <= S_MERGE_N;
                        end
                    end
                end
                S_MERGE_N: begin
                    r_op <= w_mn ? ffpa_pkg::OP_MERGE_NEXT : ffpa_pkg::OP_NONE;
                    r_state <= S_MERGE_P;
                end
                S_MERGE_P: begin
                    // wait while the next-entry merge is being applied
                    if (r_op == ffpa_pkg::OP_NONE) begin
                        if (w_mp) begin
                            r_op <= ffpa_pkg::OP_MERGE_PREV; r_opidx <= w_pv;
                        end else begin
                            r_op <= ffpa_pkg::OP_NONE;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_op <= ffpa_pkg::OP_NONE;
                    end
                end
                S_OUT: begin
                    r_op <= ffpa_pkg::OP_NONE;
                    if (!r_oval || !i_stall) begin
                        r_oval <= 1'b1;
                        r_status <= r_res_status;
                        if (r_res_status != ffpa_pkg::ST_DONE) begin
                            r_rs <= '0; r_rl <= '0;
                        end else begin
                            r_rs <= r_res_start; r_rl <= r_res_len;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_op <= ffpa_pkg::OP_NONE;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_oval;
    assign o_status       = r_status;
    assign o_block_start  = r_rs;
    assign o_block_length = r_rl;
endmodule

// ----- design/ffpa_checker.sv -----
// Port-level checker for the first-fit partition allocator.
`timescale 1ns / 1ps
module ffpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [15:0] o_block_start,
    input logic [15:0] o_block_length
);
    // a stalled result holds its status and length
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_block_length))
        else $error("result changed while stalled");
    // error results carry no block
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ffpa_pkg::ST_DONE
        |-> o_block_start == 16'd0 && o_block_length == 16'd0)
        else $error("error result with nonzero block");
    // an accepted request always starts work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accept did not start work");
    // no result comes out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind first_fit_partition_allocator ffpa_checker u_ffpa_checker (.*);

// ----- test/first_fit_partition_allocator_tb.sv -----
// Testbench: first-fit partition allocator checked against an in-bench table model.
`timescale 1ns / 1ps
module first_fit_partition_allocator_tb;

    localparam int ENTRIES   = 16;
    localparam int MAX_CYCLES = 2000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic        command;
        logic [7:0]  job_id;
        logic [15:0] request_size;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_start;
        logic [15:0] block_length;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = 1'b0;
    logic [7:0]  i_job_id = '0;
    logic [15:0] i_request_size = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_block_start;
    logic [15:0] o_block_length;

    first_fit_partition_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_job_id(i_job_id), .i_request_size(i_request_size),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_block_start(o_block_start), .o_block_length(o_block_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow partition table
    logic [15:0] tbl_start [ENTRIES];
    logic [15:0] tbl_length[ENTRIES];
    logic [7:0]  tbl_owner [ENTRIES];
    logic        tbl_used  [ENTRIES];
    int          tbl_count;

    t_request pending_requests[$];
    t_result  expected_results[$];
    int  failures = 0;
    int  send_idle_pct = 6;
    int  recv_idle_pct = 82;
    bit  hold_req = 1'b0;
    int  hold_count = 0;
    bit  in_taken = 1'b0;
    longint cycle_count = 0;

    function automatic void table_reset();
        for (int k = 0; k < ENTRIES; k++) begin
            tbl_start[k] = '0; tbl_length[k] = '0; tbl_owner[k] = '0; tbl_used[k] = 1'b0;
        end
        tbl_start[0] = 16'd0;    tbl_length[0] = 16'd200;
        tbl_start[1] = 16'd300;  tbl_length[1] = 16'd500;
        tbl_start[2] = 16'd1000; tbl_length[2] = 16'd1000;
        tbl_count = 3;
    endfunction

    function automatic void table_remove(int idx);
        for (int k = idx; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1]; tbl_length[k] = tbl_length[k+1];
            tbl_owner[k] = tbl_owner[k+1]; tbl_used[k] = tbl_used[k+1];
        end
        tbl_count--;
        tbl_start[tbl_count] = '0; tbl_length[tbl_count] = '0;
        tbl_owner[tbl_count] = '0; tbl_used[tbl_count] = 1'b0;
    endfunction

    // Apply one request to the shadow table and return its result
    function automatic t_result allocate_or_free(t_request req);
        t_result r;
        int i;
        logic [15:0] s, l;
        r = '0;
        r.status = ffpa_pkg::ST_DONE;
        if (req.command == ffpa_pkg::CMD_ALLOC) begin
            for (i = 0; i < tbl_count; i++)
                if (!tbl_used[i] && tbl_length[i] >= req.request_size) break;
            if (req.request_size == 0 || i >= tbl_count) begin
                r.status = ffpa_pkg::ST_NO_FIT;
            end else if (tbl_length[i] == req.request_size) begin
                tbl_used[i] = 1'b1; tbl_owner[i] = req.job_id;
                r.block_start = tbl_start[i]; r.block_length = req.request_size;
            end else if (tbl_count >= ENTRIES) begin
                r.status = ffpa_pkg::ST_FULL;
            end else begin
                s = tbl_start[i]; l = tbl_length[i];
                for (int k = tbl_count; k > i; k--) begin
                    tbl_start[k] = tbl_start[k-1]; tbl_length[k] = tbl_length[k-1];
                    tbl_owner[k] = tbl_owner[k-1]; tbl_used[k] = tbl_used[k-1];
                end
                tbl_count++;
                tbl_length[i] = req.request_size; tbl_owner[i] = req.job_id; tbl_used[i] = 1'b1;
                tbl_start[i+1] = s + req.request_size; tbl_length[i+1] = l - req.request_size;
                tbl_owner[i+1] = '0; tbl_used[i+1] = 1'b0;
                r.block_start = s; r.block_length = req.request_size;
            end
        end else begin
            for (i = 0; i < tbl_count; i++)
                if (tbl_used[i] && tbl_owner[i] == req.job_id) break;
            if (i >= tbl_count) begin
                r.status = ffpa_pkg::ST_NO_JOB;
            end else begin
                r.block_start = tbl_start[i]; r.block_length = tbl_length[i];
                tbl_used[i] = 1'b0; tbl_owner[i] = '0;
                if (i + 1 < tbl_count && !tbl_used[i+1]
                        && 16'(tbl_start[i] + tbl_length[i]) == tbl_start[i+1]) begin
                    tbl_length[i] = tbl_length[i] + tbl_length[i+1];
                    table_remove(i + 1);
                end
                if (i > 0 && !tbl_used[i-1]
                        && 16'(tbl_start[i-1] + tbl_length[i-1]) == tbl_start[i]) begin
                    tbl_length[i-1] = tbl_length[i-1] + tbl_length[i];
                    table_remove(i);
                end
            end
        end
        return r;
    endfunction

    function automatic t_request make_req(logic cmd, int job, int size);
        t_request q;
        q.command = cmd; q.job_id = 8'(job); q.request_size = 16'(size);
        return q;
    endfunction

    // Append one request to the pending list
    task automatic enqueue_req(t_request q);
        pending_requests = {pending_requests, q};
    endtask

    // Driver: offer pending requests, change inputs on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (pending_requests.size() > 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    t_request q;
                    q = pending_requests.pop_front();
                    i_valid <= 1'b1;
                    i_command <= q.command;
                    i_job_id <= q.job_id;
                    i_request_size <= q.request_size;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= (hold_req && hold_count < HOLD_CYCLES)
                       || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Receiver hold-off: counts its cycles once requested
    always @(posedge i_clk) begin
        if (hold_req && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_results = {expected_results, allocate_or_free(
                    make_req(i_command, i_job_id, i_request_size))};
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result status=%0d start=%0d length=%0d",
                           o_status, o_block_start, o_block_length);
                    failures++;
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_status);
                        failures++;
                    end
                    if (o_block_start !== e.block_start) begin
                        $error("block_start expected %0d actual %0d",
                               e.block_start, o_block_start);
                        failures++;
                    end
                    if (o_block_length !== e.block_length) begin
                        $error("block_length expected %0d actual %0d",
                               e.block_length, o_block_length);
                        failures++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycle_count > MAX_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Random requests: mostly allocs and frees over a small job pool
    task automatic queue_random(int count);
        int roll, size;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 5)
                size = $urandom_range(65535);
            else if (roll < 60)
                size = $urandom_range(1, 120);
            else if (roll < 85)
                size = $urandom_range(1, 600);
            else
                size = $urandom_range(1, 1100);
            if ($urandom_range(99) < 8)
                enqueue_req(make_req(1'($urandom_range(1)), $urandom_range(255),
                                     int'($urandom)));
            else
                enqueue_req(make_req($urandom_range(99) < 52 ? ffpa_pkg::CMD_ALLOC
                                                             : ffpa_pkg::CMD_FREE,
                                     $urandom_range(99) < 85 ?
                                     $urandom_range(1, 12) : $urandom_range(255),
                                     size));
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        table_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, exact fit, zero size, unknown job, duplicates, merges
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 0, 0));
        enqueue_req(make_req(ffpa_pkg::CMD_FREE, 5, 0));
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 255, 65535));
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 1, 200));
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 2, 100));
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 2, 100));
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 3, 300));
        enqueue_req(make_req(ffpa_pkg::CMD_FREE, 2, 16'hFFFF));
        enqueue_req(make_req(ffpa_pkg::CMD_FREE, 3, 0));
        enqueue_req(make_req(ffpa_pkg::CMD_FREE, 2, 0));
        enqueue_req(make_req(ffpa_pkg::CMD_FREE, 1, 0));
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 170, 1000));
        enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 85, 1001));
        enqueue_req(make_req(ffpa_pkg::CMD_FREE, 170, 0));
        // Fill the table with small splits to reach the full case
        for (int k = 0; k < 15; k++)
            enqueue_req(make_req(ffpa_pkg::CMD_ALLOC, 20 + k, 1));
        for (int k = 0; k < 15; k++)
            enqueue_req(make_req(ffpa_pkg::CMD_FREE, 20 + k, 0));
        wait_drained();

        // Sender rarely idles, receiver mostly stalls
        queue_random(500);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        hold_req = 1'b1;
        queue_random(40);
        wait (hold_count == HOLD_CYCLES);
        hold_req = 1'b0;
        wait_drained();

        send_idle_pct = 82; recv_idle_pct = 6;
        queue_random(450);
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        queue_random(500);
        wait_drained();

        repeat (100) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
